// ===== design/rfd_pkg.sv =====
// Shared types and constants for the RPC frame deframer.
// No dependencies.
package rfd_pkg;

    localparam int unsigned ID_MAX_DEFAULT   = 128;
    localparam int unsigned TEXT_MAX_DEFAULT = 512;
    localparam logic [16:0] FIXED_OVERHEAD   = 17'd26;
    localparam int unsigned QUEUE_DEPTH      = 4;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_INFO    = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_ERRCODE = 3'd4,
        KIND_OK      = 3'd5,
        KIND_ERR     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_END   = 2'd1,
        REG_MAXLEN = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [16:0] max_frame_length;
    } cfg_t;

endpackage

// ===== design/rfd_cfg.sv =====
// Configuration register file on an APB-style port.
// Depends on rfd_pkg.
module rfd_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rfd_pkg::cfg_t cfg
);
    import rfd_pkg::*;

    logic [7:0]  start_reg;
    logic [7:0]  end_reg;
    logic [16:0] max_reg;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 8'd2;
            end_reg   <= 8'd3;
            max_reg   <= 17'd65536;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_START:  start_reg <= pwdata[7:0];
                REG_END:    end_reg   <= pwdata[7:0];
                REG_MAXLEN: max_reg   <= pwdata[16:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START:  prdata = {24'd0, start_reg};
            REG_END:    prdata = {24'd0, end_reg};
            REG_MAXLEN: prdata = {15'd0, max_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg = '{start_marker: start_reg, end_marker: end_reg, max_frame_length: max_reg};

endmodule

// ===== design/rfd_parser.sv =====
// Front end: walks the frame one byte per cycle while in_valid is high and classifies each byte.
// Depends on rfd_pkg.
module rfd_parser #(
    parameter int unsigned ID_MAX_BYTES   = rfd_pkg::ID_MAX_DEFAULT,
    parameter int unsigned TEXT_MAX_BYTES = rfd_pkg::TEXT_MAX_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      data_byte,
    input  rfd_pkg::cfg_t   cfg,
    output logic            res_valid,
    output rfd_pkg::result_t res
);
    import rfd_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT, PH_TOTAL, PH_IDLEN, PH_ID, PH_NAMELEN, PH_NAME, PH_ERRCODE,
        PH_INFOLEN, PH_INFO, PH_PAYLOAD, PH_CHECK, PH_END, PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [16:0] total_reg, total_next;
    logic [31:0] shift_reg, shift_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] sum_reg, sum_next;
    logic [1:0]  wcnt_reg, wcnt_next;

    logic        word_done;
    logic [31:0] word;
    logic [16:0] pos_inc;
    logic [16:0] rem_dec;
    logic [33:0] len_end;
    logic        len_bad;
    logic [31:0] limit;
    logic [16:0] payload_len;
    logic        total_bad;

    assign word      = {shift_reg[23:0], data_byte};
    assign word_done = (wcnt_reg == 2'd3);
    assign pos_inc   = pos_reg + 17'd1;
    assign rem_dec   = rem_reg - 17'd1;
    assign limit     = (phase_reg == PH_IDLEN) ? 32'(ID_MAX_BYTES) : 32'(TEXT_MAX_BYTES);
    assign len_end   = 34'(sum_reg) + 34'(word) + 34'(FIXED_OVERHEAD);
    assign len_bad   = (word > limit) || (len_end > 34'(total_reg));
    assign total_bad = (word < 32'(FIXED_OVERHEAD)) || (word > 32'(cfg.max_frame_length));
    assign payload_len = total_reg - sum_reg - FIXED_OVERHEAD;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        wcnt_next  = wcnt_reg;
        res_valid  = 1'b0;
        res        = '{kind: KIND_ERR, value: 32'd0, last: 1'b1};
        if (in_valid)
        begin
            if (phase_reg != PH_HUNT)
            begin
                pos_next = pos_inc;
            end
            if (phase_reg == PH_TOTAL || phase_reg == PH_IDLEN || phase_reg == PH_NAMELEN
                || phase_reg == PH_ERRCODE || phase_reg == PH_INFOLEN)
            begin
                shift_next = word;
                wcnt_next  = wcnt_reg + 2'd1;
            end
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == cfg.start_marker)
                    begin
                        pos_next   = 17'd1;
                        sum_next   = 17'd0;
                        total_next = 17'd0;
                        wcnt_next  = 2'd0;
                        phase_next = PH_TOTAL;
                    end
                end
                PH_TOTAL:
                begin
                    if (word_done)
                    begin
                        total_next = word[16:0];
                        if (total_bad)
                        begin
                            phase_next = PH_HUNT;
                            res_valid  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLEN;
                        end
                    end
                end
                PH_IDLEN, PH_NAMELEN, PH_INFOLEN:
                begin
                    if (word_done)
                    begin
                        if (len_bad)
                        begin
                            res_valid = 1'b1;
                            if (pos_inc >= total_reg)
                            begin
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                rem_next   = total_reg - pos_inc;
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            sum_next = sum_reg + word[16:0];
                            rem_next = word[16:0];
                            if (phase_reg == PH_IDLEN)
                            begin
                                phase_next = (word == 32'd0) ? PH_NAMELEN : PH_ID;
                            end
                            else if (phase_reg == PH_NAMELEN)
                            begin
                                phase_next = (word == 32'd0) ? PH_ERRCODE : PH_NAME;
                            end
                            else if (word != 32'd0)
                            begin
                                phase_next = PH_INFO;
                            end
                            else
                            begin
                                // no info bytes: go straight to payload, or to the check if the payload is empty
                                rem_next = total_reg - (sum_reg + word[16:0]) - FIXED_OVERHEAD;
                                phase_next = (rem_next == 17'd0) ? PH_CHECK : PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_ID, PH_NAME, PH_INFO, PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    res.value = {24'd0, data_byte};
                    res.last  = 1'b0;
                    rem_next  = rem_dec;
                    unique case (phase_reg)
                        PH_ID:   res.kind = KIND_ID;
                        PH_NAME: res.kind = KIND_NAME;
                        PH_INFO: res.kind = KIND_INFO;
                        default: res.kind = KIND_PAYLOAD;
                    endcase
                    if (rem_dec == 17'd0)
                    begin
                        unique case (phase_reg)
                            PH_ID:   phase_next = PH_NAMELEN;
                            PH_NAME: phase_next = PH_ERRCODE;
                            PH_INFO:
                            begin
                                rem_next   = payload_len;
                                phase_next = (payload_len == 17'd0) ? PH_CHECK : PH_PAYLOAD;
                            end
                            default: phase_next = PH_CHECK;
                        endcase
                    end
                end
                PH_ERRCODE:
                begin
                    if (word_done)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERRCODE;
                        res.value  = word;
                        res.last   = 1'b0;
                        phase_next = PH_INFOLEN;
                    end
                end
                PH_CHECK:
                begin
                    wcnt_next = wcnt_reg + 2'd1;
                    if (word_done)
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    res_valid  = 1'b1;
                    res.kind   = (data_byte == cfg.end_marker) ? KIND_OK : KIND_ERR;
                    phase_next = PH_HUNT;
                end
                PH_SKIP:
                begin
                    if (rem_reg <= 17'd1)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        rem_next = rem_dec;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 17'd0;
            total_reg <= 17'd0;
            shift_reg <= 32'd0;
            rem_reg   <= 17'd0;
            sum_reg   <= 17'd0;
            wcnt_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            sum_reg   <= sum_next;
            wcnt_reg  <= wcnt_next;
        end
    end

endmodule

// ===== design/rfd_queue.sv =====
// Result queue between the parser and the consumer.
// Depends on rfd_pkg.
module rfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  rfd_pkg::result_t wr_data,
    input  logic             rd_en,
    output rfd_pkg::result_t rd_data,
    output logic             empty,
    output logic             full
);
    import rfd_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    result_t       mem [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign empty   = (cnt_reg == '0);
    // the parser writes at the edge that takes its byte, so every slot is usable
    assign full    = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

// ===== design/rpc_frame_deframer.sv =====
// Top level of the RPC frame deframer: registers, parser and result queue.
// Depends on rfd_pkg, rfd_cfg, rfd_parser, rfd_queue.
//
// Channel   Handshake           Payload
// input     push / full         data_byte
// result    empty / pop         kind, value, frame_last
// config    APB psel/penable    paddr, pwdata, prdata
//
// One byte is taken per cycle unless full is high; its result reaches the queue in the same edge.
// The parser keeps one phase register and a few counters, so bytes stream
// back to back. full rises when the four-word result queue holds four words.
// Reset returns to start-byte search with registers at their defaults.
module rpc_frame_deframer #(
    parameter int unsigned ID_MAX_BYTES   = rfd_pkg::ID_MAX_DEFAULT,
    parameter int unsigned TEXT_MAX_BYTES = rfd_pkg::TEXT_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [31:0] value,
    output logic        frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rfd_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t head;
    logic    res_valid;
    logic    accept;
    logic    q_empty;

    assign accept = push & ~full;

    rfd_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    rfd_parser #(
        .ID_MAX_BYTES(ID_MAX_BYTES),
        .TEXT_MAX_BYTES(TEXT_MAX_BYTES)
    ) u_parser (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .data_byte(data_byte),
        .cfg(cfg), .res_valid(res_valid), .res(res)
    );

    rfd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(res_valid), .wr_data(res),
        .rd_en(pop & ~q_empty), .rd_data(head), .empty(q_empty), .full(full)
    );

    assign empty      = q_empty;
    assign kind       = head.kind;
    assign value      = head.value;
    assign frame_last = head.last;

endmodule
